FILE: src/line_billboard_quad_expand_unit_defines.svh
// Assertion macros for the line billboard quad expand unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LINE_BILLBOARD_QUAD_EXPAND_UNIT_DEFINES_SVH
`define LINE_BILLBOARD_QUAD_EXPAND_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBQE_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBQE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lbqe_pkg.sv
// Shared types, constants and step functions for the line quad expander.
// No dependencies; imported by line_billboard_quad_expand_unit.
package lbqe_pkg;

	localparam int COORD_W   = 32;
	localparam int WIDTH_W   = 31;
	localparam int COLOR_W   = 32;
	localparam int REG_IDX_W = 2;
	localparam int IN_DATA_W = 256;
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

	localparam int ROOT_STEPS = 32;
	localparam int QUOT_STEPS = 32;

	// bit position the largest cross product magnitude is normalized to
	localparam logic [5:0] NORM_MSB = 6'd29;
	localparam logic [1:0] VTX_LAST = 2'd3;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t [2:0]       p0;
		coord_t [2:0]       p1;
		logic [WIDTH_W-1:0] w;
		logic [COLOR_W-1:0] color;
	} seg_t;

	typedef struct packed {
		seg_t             seg;
		logic [2:0]       neg;
		logic             nz;
		logic [2:0][60:0] mw;
		logic [63:0]      rad;
		logic [63:0]      root;
	} root_t;

	typedef struct packed {
		seg_t             seg;
		logic [2:0]       neg;
		logic             nz;
		logic [31:0]      dvs;
		logic [2:0][32:0] rem;
		logic [2:0][31:0] lo;
		logic [2:0][31:0] quo;
	} quot_t;

	typedef struct packed {
		seg_t             seg;
		logic [2:0][32:0] h;
	} quad_t;

	// One digit of the restoring integer square root; step 0 tests bit 62.
	function automatic root_t root_step(root_t a, logic [4:0] idx);
		root_t       b;
		logic [63:0] bitv;
		logic [63:0] trial;
		b     = a;
		bitv  = 64'h4000_0000_0000_0000 >> {idx, 1'b0};
		trial = a.root + bitv;
		if (a.rad >= trial) begin
			b.rad  = a.rad - trial;
			b.root = (a.root >> 1) + bitv;
		end else begin
			b.root = a.root >> 1;
		end
		return b;
	endfunction

	// One quotient bit on each of the three lanes.
	function automatic quot_t quot_step(quot_t a);
		quot_t       b;
		logic [32:0] t;
		b = a;
		for (int i = 0; i < 3; i++) begin
			t        = {a.rem[i][31:0], a.lo[i][31]};
			b.lo[i]  = {a.lo[i][30:0], 1'b0};
			if (t >= {1'b0, a.dvs}) begin
				b.rem[i] = t - {1'b0, a.dvs};
				b.quo[i] = {a.quo[i][30:0], 1'b1};
			end else begin
				b.rem[i] = t;
				b.quo[i] = {a.quo[i][30:0], 1'b0};
			end
		end
		return b;
	endfunction

endpackage

FILE: src/line_billboard_quad_expand_unit.sv
// Line billboard quad expander: one segment in, four camera-facing quad vertices out.
// Depends on lbqe_pkg and line_billboard_quad_expand_unit_defines.svh.
//
// Usage:
//   cfg channel: write camera_x/y/z (index 0/1/2) while the unit is idle; other indexes
//   are dropped. cfg_ready is always high.
//   s_axis: one segment word per handshake (endpoints, width, color).
//   m_axis: four vertex words per segment, in order start+side, start-side, end+side,
//   end-side; tuser carries tex_u and tex_v, tlast marks the fourth vertex.
// Path: front stages s1 to s9, root lanes, divider lanes, emitter register, output register;
//   after the first vertex the rest follow one a cycle while m_axis_tready is high.
// Throughput: set by the output channel, which moves one vertex per cycle while m_axis_tready
//   is high; the pipeline (front math, square root lanes, divider lanes) takes a word
//   in any cycle the vertex emitter can release its current quad.
// Reset: clears all valid bits, the vertex counter and the camera registers to zero.
// Stall: while m_axis_tvalid waits on m_axis_tready the output word and the emitter's quad
//   hold; a held quad freezes the whole pipeline and drops s_axis_tready; nothing is lost.
`include "line_billboard_quad_expand_unit_defines.svh"

module line_billboard_quad_expand_unit #(
	parameter int ROOT_PER_STAGE = 2,
	parameter int QUOT_PER_STAGE = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lbqe_pkg::REG_IDX_W-1:0]     cfg_addr,
	input  logic [31:0]                        cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, line_width, line_color, pad
	input  logic [lbqe_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// vert_x, vert_y, vert_z, vert_color
	output logic [lbqe_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// tex_u, tex_v
	output logic [lbqe_pkg::OUT_USER_W-1:0]    m_axis_tuser,
	output logic                               m_axis_tlast
);
	import lbqe_pkg::*;

	localparam int ROOT_STAGES = ROOT_STEPS / ROOT_PER_STAGE;
	localparam int QUOT_STAGES = QUOT_STEPS / QUOT_PER_STAGE;

	logic [2:0][31:0] cam_q;
	logic             adv;
	seg_t             in_seg;

	// front pipeline
	logic [9:1]        vld_s;
	seg_t              seg_s1, seg_s2, seg_s3, seg_s4, seg_s5, seg_s6, seg_s7, seg_s8, seg_s9;
	logic signed [32:0] d_s1 [3];
	logic signed [34:0] v_s1 [3];
	logic [32:0]       dm_s2 [3];
	logic [33:0]       vm_s2 [3];
	logic [2:0]        dn_s2, vn_s2;
	logic signed [30:0] dq_s3 [3];
	logic signed [30:0] vq_s3 [3];
	logic signed [61:0] pr_s4 [6];
	logic signed [62:0] x_s5 [3];
	logic [61:0]       xm_s6 [3];
	logic [2:0]        xn_s6;
	logic [61:0]       xm_s7 [3];
	logic [2:0]        xn_s7;
	logic [5:0]        pos_s7;
	logic              nz_s7;
	logic [29:0]       nm_s8 [3];
	logic [2:0]        xn_s8;
	logic              nz_s8;
	logic [59:0]       sq_s9 [3];
	logic [60:0]       mw_s9 [3];
	logic [2:0]        xn_s9;
	logic              nz_s9;

	logic [2:0]  dsh, vsh;
	logic [29:0] dt [3];
	logic [29:0] vt [3];
	logic [62:0] xa [3];
	logic [61:0] x_or;
	logic [5:0]  pos;
	logic [29:0] nm [3];

	root_t rt_s [ROOT_STAGES+1];
	logic  rt_v [ROOT_STAGES+1];
	quot_t qt_s [QUOT_STAGES+1];
	logic  qt_v [QUOT_STAGES+1];
	quot_t qt_init;
	logic [61:0] num [3];
	quad_t quad_fin;

	// emitter and output register
	quad_t                e_q;
	logic                 e_vld_q;
	logic [1:0]           k_q;
	logic                 o_vld_q;
	logic [OUT_DATA_W-1:0] o_data_q;
	logic [OUT_USER_W-1:0] o_user_q;
	logic                 o_last_q;
	logic                 o_load, e_done;
	coord_t [2:0]         pk;
	logic signed [33:0]   vsum [3];
	logic [2:0][31:0]     vsat;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				REG_CAMERA_X: cam_q[0] <= cfg_data;
				REG_CAMERA_Y: cam_q[1] <= cfg_data;
				REG_CAMERA_Z: cam_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// input unpack
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_seg.p0[i] = s_axis_tdata[32*i +: 32];
			in_seg.p1[i] = s_axis_tdata[96+32*i +: 32];
		end
		in_seg.w     = s_axis_tdata[222:192];
		in_seg.color = s_axis_tdata[254:223];
	end

	// handshake and emitter control
	assign o_load        = e_vld_q && (!o_vld_q || m_axis_tready);
	assign e_done        = o_load && (k_q == VTX_LAST);
	assign adv           = !e_vld_q || e_done;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[8:1], s_axis_tvalid};
		end
	end

	// shift counts that bring each vector below 2^30
	always_comb begin
		logic [32:0] dor;
		logic [33:0] vor;
		dor = dm_s2[0] | dm_s2[1] | dm_s2[2];
		vor = vm_s2[0] | vm_s2[1] | vm_s2[2];
		priority if (dor[32]) dsh = 3'd3;
		else if (dor[31])     dsh = 3'd2;
		else if (dor[30])     dsh = 3'd1;
		else                  dsh = 3'd0;
		priority if (vor[33]) vsh = 3'd4;
		else if (vor[32])     vsh = 3'd3;
		else if (vor[31])     vsh = 3'd2;
		else if (vor[30])     vsh = 3'd1;
		else                  vsh = 3'd0;
		for (int i = 0; i < 3; i++) begin
			dt[i] = 30'(dm_s2[i] >> dsh);
			vt[i] = 30'(vm_s2[i] >> vsh);
		end
	end

	// magnitude of the cross product, leading one, normalize
	always_comb begin
		for (int i = 0; i < 3; i++)
			xa[i] = x_s5[i][62] ? 63'(-x_s5[i]) : 63'(x_s5[i]);
		x_or = xm_s7[0] | xm_s7[1] | xm_s7[2];
		pos  = '0;
		for (int b = 0; b < 62; b++)
			if (xm_s6[0][b] | xm_s6[1][b] | xm_s6[2][b])
				pos = 6'(b);
		for (int i = 0; i < 3; i++) begin
			if (pos_s7 >= NORM_MSB)
				nm[i] = 30'(xm_s7[i] >> (pos_s7 - NORM_MSB));
			else
				nm[i] = 30'(xm_s7[i] << (NORM_MSB - pos_s7));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: direction and doubled view vector
			seg_s1 <= in_seg;
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= 33'($signed(in_seg.p1[i])) - 33'($signed(in_seg.p0[i]));
				v_s1[i] <= $signed({cam_q[i][31], cam_q[i][31], cam_q[i], 1'b0})
					- 35'($signed(in_seg.p0[i])) - 35'($signed(in_seg.p1[i]));
			end
			// s2: sign and magnitude
			seg_s2 <= seg_s1;
			for (int i = 0; i < 3; i++) begin
				dn_s2[i] <= d_s1[i][32];
				vn_s2[i] <= v_s1[i][34];
				dm_s2[i] <= d_s1[i][32] ? 33'(-d_s1[i]) : 33'(d_s1[i]);
				vm_s2[i] <= v_s1[i][34] ? 34'(-v_s1[i]) : 34'(v_s1[i]);
			end
			// s3: fit both vectors below 2^30, truncating toward zero
			seg_s3 <= seg_s2;
			for (int i = 0; i < 3; i++) begin
				dq_s3[i] <= dn_s2[i] ? -$signed({1'b0, dt[i]}) : $signed({1'b0, dt[i]});
				vq_s3[i] <= vn_s2[i] ? -$signed({1'b0, vt[i]}) : $signed({1'b0, vt[i]});
			end
			// s4: cross product partial products
			seg_s4   <= seg_s3;
			pr_s4[0] <= dq_s3[1] * vq_s3[2];
			pr_s4[1] <= dq_s3[2] * vq_s3[1];
			pr_s4[2] <= dq_s3[2] * vq_s3[0];
			pr_s4[3] <= dq_s3[0] * vq_s3[2];
			pr_s4[4] <= dq_s3[0] * vq_s3[1];
			pr_s4[5] <= dq_s3[1] * vq_s3[0];
			// s5: cross product
			seg_s5  <= seg_s4;
			x_s5[0] <= 63'(pr_s4[0]) - 63'(pr_s4[1]);
			x_s5[1] <= 63'(pr_s4[2]) - 63'(pr_s4[3]);
			x_s5[2] <= 63'(pr_s4[4]) - 63'(pr_s4[5]);
			// s6: magnitudes
			seg_s6 <= seg_s5;
			for (int i = 0; i < 3; i++) begin
				xn_s6[i] <= x_s5[i][62];
				xm_s6[i] <= 62'(xa[i]);
			end
			// s7: leading one of the largest magnitude
			seg_s7 <= seg_s6;
			xm_s7  <= xm_s6;
			xn_s7  <= xn_s6;
			pos_s7 <= pos;
			nz_s7  <= |(xm_s6[0] | xm_s6[1] | xm_s6[2]);
			// s8: normalize to [2^29, 2^30)
			seg_s8 <= seg_s7;
			nm_s8  <= nm;
			xn_s8  <= xn_s7;
			nz_s8  <= nz_s7 && (x_or != '0);
			// s9: squares and width products
			seg_s9 <= seg_s8;
			xn_s9  <= xn_s8;
			nz_s9  <= nz_s8;
			for (int i = 0; i < 3; i++) begin
				sq_s9[i] <= nm_s8[i] * nm_s8[i];
				mw_s9[i] <= nm_s8[i] * seg_s8.w;
			end
			// sum of squares enters the root lanes
			rt_s[0].seg  <= seg_s9;
			rt_s[0].neg  <= xn_s9;
			rt_s[0].nz   <= nz_s9;
			for (int i = 0; i < 3; i++)
				rt_s[0].mw[i] <= mw_s9[i];
			rt_s[0].rad  <= 64'(sq_s9[0]) + 64'(sq_s9[1]) + 64'(sq_s9[2]);
			rt_s[0].root <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v[0] <= 1'b0;
		end else if (adv) begin
			rt_v[0] <= vld_s[9];
		end
	end

	// square root, ROOT_PER_STAGE digits per stage
	for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
		root_t nxt;
		always_comb begin
			nxt = rt_s[g];
			for (int j = 0; j < ROOT_PER_STAGE; j++)
				nxt = root_step(nxt, 5'(g*ROOT_PER_STAGE + j));
		end
		always_ff @(posedge clk) begin
			if (adv)
				rt_s[g+1] <= nxt;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[g+1] <= 1'b0;
			end else if (adv) begin
				rt_v[g+1] <= rt_v[g];
			end
		end
	end

	// dividend |X|*W + L over divisor 2L, rounds half away from zero
	always_comb begin
		qt_init.seg = rt_s[ROOT_STAGES].seg;
		qt_init.neg = rt_s[ROOT_STAGES].neg;
		qt_init.nz  = rt_s[ROOT_STAGES].nz;
		qt_init.dvs = {rt_s[ROOT_STAGES].root[30:0], 1'b0};
		for (int i = 0; i < 3; i++) begin
			num[i] = 62'(rt_s[ROOT_STAGES].mw[i]) + 62'(rt_s[ROOT_STAGES].root[31:0]);
			qt_init.rem[i] = 33'(num[i][61:32]);
			qt_init.lo[i]  = num[i][31:0];
			qt_init.quo[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			qt_s[0] <= qt_init;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qt_v[0] <= 1'b0;
		end else if (adv) begin
			qt_v[0] <= rt_v[ROOT_STAGES];
		end
	end

	// divider lanes, QUOT_PER_STAGE quotient bits per stage
	for (genvar g = 0; g < QUOT_STAGES; g++) begin : g_quot
		quot_t nxt;
		always_comb begin
			nxt = qt_s[g];
			for (int j = 0; j < QUOT_PER_STAGE; j++)
				nxt = quot_step(nxt);
		end
		always_ff @(posedge clk) begin
			if (adv)
				qt_s[g+1] <= nxt;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qt_v[g+1] <= 1'b0;
			end else if (adv) begin
				qt_v[g+1] <= qt_v[g];
			end
		end
	end

	// half side vector; zero when the cross product vanished
	always_comb begin
		quad_fin.seg = qt_s[QUOT_STAGES].seg;
		for (int i = 0; i < 3; i++) begin
			if (!qt_s[QUOT_STAGES].nz)
				quad_fin.h[i] = '0;
			else if (qt_s[QUOT_STAGES].neg[i])
				quad_fin.h[i] = -33'(qt_s[QUOT_STAGES].quo[i]);
			else
				quad_fin.h[i] = 33'(qt_s[QUOT_STAGES].quo[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			e_q <= quad_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_vld_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (adv)
				e_vld_q <= qt_v[QUOT_STAGES];
			if (o_load)
				k_q <= k_q + 2'd1;
		end
	end

	// vertex position with saturation
	always_comb begin
		pk = k_q[1] ? e_q.seg.p1 : e_q.seg.p0;
		for (int i = 0; i < 3; i++) begin
			if (!k_q[0])
				vsum[i] = 34'($signed(pk[i])) + 34'($signed(e_q.h[i]));
			else
				vsum[i] = 34'($signed(pk[i])) - 34'($signed(e_q.h[i]));
			if (vsum[i][33:31] == 3'b000 || vsum[i][33:31] == 3'b111)
				vsat[i] = vsum[i][31:0];
			else if (vsum[i][33])
				vsat[i] = 32'h8000_0000;
			else
				vsat[i] = 32'h7fff_ffff;
		end
	end

	always_ff @(posedge clk) begin
		if (o_load) begin
			o_data_q <= {e_q.seg.color, vsat[2], vsat[1], vsat[0]};
			o_user_q <= {!k_q[0], k_q[1]};
			o_last_q <= (k_q == VTX_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
		end else if (o_load) begin
			o_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			o_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = o_vld_q;
	assign m_axis_tdata  = o_data_q;
	assign m_axis_tuser  = o_user_q;
	assign m_axis_tlast  = o_last_q;

	`LBQE_ASSERT_NOW(a_idle_index, clk, arst_n, !e_vld_q, k_q == 2'd0, "vertex index not at zero while emitter empty")
	`LBQE_ASSERT_NEXT(a_quad_wrap, clk, arst_n, e_done, k_q == 2'd0, "vertex index did not wrap after fourth vertex")
	`LBQE_ASSERT_NOW(a_last_flags, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == 2'b01, "last vertex without end minus side texture")
	`LBQE_ASSERT_NOW(a_root_range, clk, arst_n, rt_v[ROOT_STAGES] && rt_s[ROOT_STAGES].nz, (rt_s[ROOT_STAGES].root[63:31] == '0) && (rt_s[ROOT_STAGES].root[30:29] != 2'b00), "root of normalized cross product out of range")
	`LBQE_ASSERT_NOW(a_quot_fits, clk, arst_n, qt_v[QUOT_STAGES] && qt_s[QUOT_STAGES].nz, qt_s[QUOT_STAGES].quo[31] == 1'b0, "half side quotient overflow")

endmodule

FILE: bench/line_billboard_quad_expand_unit_test.sv
// Self-checking bench for line_billboard_quad_expand_unit: segments in, four quad vertices out.
// Depends on lbqe_pkg and the unit RTL; the expected vertices come from a local fixed-point model.
`timescale 1ns / 1ps

module line_billboard_quad_expand_unit_test;
	import lbqe_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic signed [31:0] sx, sy, sz, ex, ey, ez;
		logic [30:0]        w;
		logic [31:0]        color;
	} segment_t;

	typedef struct packed {
		logic [31:0] x, y, z, color;
		logic        u, v, last;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [REG_IDX_W-1:0] cfg_addr = '0;
	logic [31:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// start_x, start_y, start_z, end_x, end_y, end_z, line_width, line_color, pad
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// vert_x, vert_y, vert_z, vert_color
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// tex_u, tex_v
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic m_axis_tlast;

	segment_t pending_segments[$];
	vertex_t  expected_vertices[$];
	longint   camera[3] = '{0, 0, 0};
	bit       gaps_on = 1'b1;
	bit       failed = 1'b0;
	segment_t in_flight;
	int       send_gap = 0;
	int       recv_stall = 0;
	int       quiet_cycles = 0;

	line_billboard_quad_expand_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned magnitude(longint a);
		return a < 0 ? -a : a;
	endfunction

	function automatic longint shift_toward_zero(longint a, int s);
		longint unsigned m;
		m = magnitude(a) >> s;
		return a < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned largest(longint a[3]);
		longint unsigned m;
		m = magnitude(a[0]);
		if (magnitude(a[1]) > m) m = magnitude(a[1]);
		if (magnitude(a[2]) > m) m = magnitude(a[2]);
		return m;
	endfunction

	// shrink a vector until every component is below 2^30
	function automatic void fit_below(inout longint a[3]);
		int s;
		longint unsigned m;
		s = 0;
		m = largest(a);
		while ((m >> s) >= (64'd1 << 30)) s++;
		for (int i = 0; i < 3; i++) a[i] = shift_toward_zero(a[i], s);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] clamp32(longint a);
		if (a > 64'sd2147483647) return 32'h7fff_ffff;
		if (a < -64'sd2147483648) return 32'h8000_0000;
		return a[31:0];
	endfunction

	function automatic void expand_quad(segment_t sg);
		longint p0[3], p1[3], d[3], v2[3], cr[3], half[3], c;
		longint unsigned sum, len, q;
		vertex_t vx;
		p0 = '{sg.sx, sg.sy, sg.sz};
		p1 = '{sg.ex, sg.ey, sg.ez};
		half = '{0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			d[i] = p1[i] - p0[i];
			v2[i] = 2 * camera[i] - (p0[i] + p1[i]);
		end
		fit_below(d);
		fit_below(v2);
		cr[0] = d[1] * v2[2] - d[2] * v2[1];
		cr[1] = d[2] * v2[0] - d[0] * v2[2];
		cr[2] = d[0] * v2[1] - d[1] * v2[0];
		if (largest(cr) != 0) begin
			fit_below(cr);
			while (largest(cr) < (64'd1 << 29))
				for (int i = 0; i < 3; i++) cr[i] *= 2;
			sum = 0;
			for (int i = 0; i < 3; i++) sum += magnitude(cr[i]) * magnitude(cr[i]);
			len = floor_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				q = (magnitude(cr[i]) * longint'(sg.w) + len) / (2 * len);
				half[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
			end
		end
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				c = (k < 2) ? p0[i] : p1[i];
				c = (k % 2 == 0) ? c + half[i] : c - half[i];
				case (i)
					0: vx.x = clamp32(c);
					1: vx.y = clamp32(c);
					default: vx.z = clamp32(c);
				endcase
			end
			vx.color = sg.color;
			vx.u = (k >= 2);
			vx.v = (k % 2 == 0);
			vx.last = (k == 3);
			expected_vertices.push_back(vx);
		end
	endfunction

	// segment driver
	always @(posedge clk or negedge arst_n) begin
		bit fire, next_valid;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			fire = s_axis_tvalid && s_axis_tready;
			next_valid = s_axis_tvalid && !fire;
			if (fire) begin
				expand_quad(in_flight);
				quiet_cycles = 0;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (pending_segments.size() > 0) begin
					in_flight = pending_segments.pop_front();
					s_axis_tdata <= {1'b0, in_flight.color, in_flight.w, in_flight.ez, in_flight.ey,
						in_flight.ex, in_flight.sz, in_flight.sy, in_flight.sx};
					next_valid = 1'b1;
					send_gap <= gaps_on ? $urandom_range(0, 3) : 0;
				end
			end
			s_axis_tvalid <= next_valid;
		end
	end

	// vertex monitor and checker
	always @(posedge clk or negedge arst_n) begin
		vertex_t want, got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				quiet_cycles = 0;
				got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
					m_axis_tdata[127:96], m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
				if (expected_vertices.size() == 0) begin
					$display("%0t: unexpected vertex %h", $time, got);
					failed = 1'b1;
				end else begin
					want = expected_vertices.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
						got.color !== want.color || got.u !== want.u ||
						got.v !== want.v || got.last !== want.last) begin
						$display("%0t: vertex mismatch exp x=%h y=%h z=%h c=%h u=%b v=%b l=%b",
							$time, want.x, want.y, want.z, want.color, want.u, want.v, want.last);
						$display("%0t:                 got x=%h y=%h z=%h c=%h u=%b v=%b l=%b",
							$time, got.x, got.y, got.z, got.color, got.u, got.v, got.last);
						failed = 1'b1;
					end
				end
				recv_stall = gaps_on ? $urandom_range(0, 3) : 0;
			end
			if (recv_stall > 0) begin
				recv_stall = recv_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) quiet_cycles = 0;
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic write_camera(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx != REG_UNUSED) camera[idx] = longint'(signed'(value));
	endtask

	task automatic drain;
		while (pending_segments.size() > 0 || s_axis_tvalid || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord(bit wide);
		return wide ? $urandom : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
	endfunction

	task automatic add_segment(logic [31:0] sx, sy, sz, ex, ey, ez, logic [30:0] w,
		logic [31:0] color);
		segment_t sg;
		sg = {sx, sy, sz, ex, ey, ez, w, color};
		pending_segments.push_back(sg);
	endtask

	task automatic add_random(int n);
		bit wide;
		logic [30:0] w;
		for (int i = 0; i < n; i++) begin
			wide = ($urandom_range(0, 3) == 0);
			w = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
			if ($urandom_range(0, 15) == 0) begin
				// endpoints that coincide leave no direction
				logic [31:0] a, b, c;
				a = pick_coord(wide); b = pick_coord(wide); c = pick_coord(wide);
				add_segment(a, b, c, a, b, c, w, $urandom);
			end else begin
				add_segment(pick_coord(wide), pick_coord(wide), pick_coord(wide),
					pick_coord(wide), pick_coord(wide), pick_coord(wide), w, $urandom);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: camera at origin after reset
		add_segment(0, 0, 0, 0, 0, 0, 0, 0);
		add_segment(0, 0, 0, 0, 0, 0, 31'h7fff_ffff, 32'hffff_ffff);
		add_segment(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 31'h0001_0000, 32'hff00_00ff);
		add_segment(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 31'h0002_0000, 1);
		add_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 31'h7fff_ffff, 32'h1234_5678);
		add_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 31'h7fff_ffff, 32'hdead_beef);
		add_segment(32'h7fff_0000, 32'h0001_0000, 0, 32'h7fff_0000, 32'h0005_0000, 0,
			31'h7fff_ffff, 32'h8000_0000);
		add_segment(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff, 31'h4000_0000, 32'h5555_aaaa);
		add_segment(32'hffff_ffff, 1, 32'hffff_fffe, 2, 32'hffff_fffd, 3, 31'd1, 32'haaaa_5555);
		add_segment(32'h0003_0000, 32'h0004_0000, 0, 32'h0006_0000, 32'h0008_0000, 0,
			31'h0000_ffff, 32'h00ff_ff00);
		drain();

		// directed: camera on the line, then at the far extremes
		write_camera(REG_CAMERA_X, 32'h0003_0000);
		write_camera(REG_CAMERA_Y, 0);
		write_camera(REG_CAMERA_Z, 0);
		write_camera(REG_UNUSED, 32'hffff_ffff);
		add_segment(32'h0001_0000, 0, 0, 32'h0005_0000, 0, 0, 31'h0001_0000, 32'h0f0f_0f0f);
		add_segment(32'h0001_0000, 0, 0, 32'h0005_0000, 32'h0001_0000, 0, 31'h0003_0000, 7);
		drain();
		write_camera(REG_CAMERA_X, 32'h7fff_ffff);
		write_camera(REG_CAMERA_Y, 32'h8000_0000);
		write_camera(REG_CAMERA_Z, 32'h7fff_ffff);
		add_segment(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 31'h7fff_ffff, 32'hffff_ffff);
		add_segment(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 31'h7fff_ffff, 0);
		add_random(80);
		drain();

		write_camera(REG_CAMERA_X, 32'h8000_0000);
		write_camera(REG_CAMERA_Y, 32'h7fff_ffff);
		write_camera(REG_CAMERA_Z, 32'h8000_0000);
		add_random(80);
		drain();

		// back-to-back with no idling on either side
		gaps_on = 1'b0;
		write_camera(REG_CAMERA_X, pick_coord(0));
		write_camera(REG_CAMERA_Y, pick_coord(0));
		write_camera(REG_CAMERA_Z, pick_coord(0));
		add_random(80);
		drain();

		gaps_on = 1'b1;
		write_camera(REG_CAMERA_X, $urandom);
		write_camera(REG_CAMERA_Y, $urandom);
		write_camera(REG_CAMERA_Z, $urandom);
		add_random(100);
		drain();

		if (!failed) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
